>>> hw/rtl/lavg_pkg.sv
// Shared types and constants for the load average filter.
`default_nettype none
package lavg_pkg;

  localparam int FRAC_BITS  = 11;
  localparam int COUNT_W    = 8;
  localparam int LOAD_W     = 19;
  localparam int DECAY_W    = 12;
  localparam int INTERVAL_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DECAY_W-1:0]    DECAY_ONE     = DECAY_W'(1 << FRAC_BITS);
  localparam logic [LOAD_W-1:0]     LOAD_MAX      = {LOAD_W{1'b1}};
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST  = 16'd5000;
  localparam logic [DECAY_W-1:0]    DECAY_SHORT_RST  = 12'd1884;
  localparam logic [DECAY_W-1:0]    DECAY_MEDIUM_RST = 12'd2014;
  localparam logic [DECAY_W-1:0]    DECAY_LONG_RST   = 12'd2034;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 2'd0,
    CFG_DECAY_SHORT     = 2'd1,
    CFG_DECAY_MEDIUM    = 2'd2,
    CFG_DECAY_LONG      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] sample_interval;
    logic [DECAY_W-1:0]    decay_short;
    logic [DECAY_W-1:0]    decay_medium;
    logic [DECAY_W-1:0]    decay_long;
  } cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/lavg_tick_if.sv
// Request channel carrying the runnable task count of one tick.
`default_nettype none
interface lavg_tick_if;
  logic                          valid;
  logic                          ready;
  logic [lavg_pkg::COUNT_W-1:0]  active_count;

  modport source (output valid, output active_count, input ready);
  modport sink   (input valid, input active_count, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lavg_load_if.sv
// Result channel carrying the three load averages and the updated flag.
`default_nettype none
interface lavg_load_if;
  logic                         valid;
  logic                         ready;
  logic [lavg_pkg::LOAD_W-1:0]  load_one;
  logic [lavg_pkg::LOAD_W-1:0]  load_five;
  logic [lavg_pkg::LOAD_W-1:0]  load_fifteen;
  logic                         updated;

  modport source (output valid, output load_one, output load_five,
                  output load_fifteen, output updated, input ready);
  modport sink   (input valid, input load_one, input load_five,
                  input load_fifteen, input updated, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/load_average_filter_core.sv
// Top level of the load average filter.
// Takes one tick request per cycle unless the result channel stalls: the task count
// is caught in an input register, and the seed or decay update of the three
// averages and the prescaler is worked out from that register into the state and
// the result register. The state update loop sets the rate.
// Configuration writes take effect on the next cycle and are meant for idle times.
`default_nettype none
module load_average_filter_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  lavg_tick_if.sink                              tick,
  lavg_load_if.source                            load,
  input  wire logic                              cfg_we,
  input  wire logic [lavg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lavg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  lavg_pkg::cfg_t cfg;

  logic                                in_valid;
  logic [lavg_pkg::COUNT_W-1:0]        in_count;
  logic                                adv;

  logic                                seeded;
  logic [lavg_pkg::INTERVAL_W-1:0]     tick_counter;
  logic [lavg_pkg::LOAD_W-1:0]         avg_short;
  logic [lavg_pkg::LOAD_W-1:0]         avg_medium;
  logic [lavg_pkg::LOAD_W-1:0]         avg_long;

  logic [lavg_pkg::INTERVAL_W:0]       count_inc;
  logic [lavg_pkg::INTERVAL_W-1:0]     interval;
  logic                                hit;
  logic [lavg_pkg::LOAD_W-1:0]         seed;
  logic [lavg_pkg::LOAD_W-1:0]         dec_short;
  logic [lavg_pkg::LOAD_W-1:0]         dec_medium;
  logic [lavg_pkg::LOAD_W-1:0]         dec_long;
  logic [lavg_pkg::LOAD_W-1:0]         avg_short_next;
  logic [lavg_pkg::LOAD_W-1:0]         avg_medium_next;
  logic [lavg_pkg::LOAD_W-1:0]         avg_long_next;
  logic [lavg_pkg::INTERVAL_W-1:0]     tick_counter_next;
  logic                                updated_next;

  lavg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lavg_decay u_decay_short (
    .load      (avg_short),
    .decay     (cfg.decay_short),
    .count     (in_count),
    .load_next (dec_short)
  );

  lavg_decay u_decay_medium (
    .load      (avg_medium),
    .decay     (cfg.decay_medium),
    .count     (in_count),
    .load_next (dec_medium)
  );

  lavg_decay u_decay_long (
    .load      (avg_long),
    .decay     (cfg.decay_long),
    .count     (in_count),
    .load_next (dec_long)
  );

  assign adv        = in_valid && (!load.valid || load.ready);
  assign tick.ready = !in_valid || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_count <= tick.active_count;
    end
  end

  always_comb begin
    count_inc = {1'b0, tick_counter} + 1'b1;
    interval  = (cfg.sample_interval == '0) ? lavg_pkg::INTERVAL_W'(1)
                                            : cfg.sample_interval;
    hit       = count_inc >= {1'b0, interval};
    seed      = {in_count, {lavg_pkg::FRAC_BITS{1'b0}}};

    avg_short_next    = avg_short;
    avg_medium_next   = avg_medium;
    avg_long_next     = avg_long;
    tick_counter_next = tick_counter;
    updated_next      = 1'b0;
    if (!seeded) begin
      avg_short_next  = seed;
      avg_medium_next = seed;
      avg_long_next   = seed;
      updated_next    = 1'b1;
    end else if (hit) begin
      avg_short_next    = dec_short;
      avg_medium_next   = dec_medium;
      avg_long_next     = dec_long;
      tick_counter_next = '0;
      updated_next      = 1'b1;
    end else begin
      tick_counter_next = count_inc[lavg_pkg::INTERVAL_W-1:0];
    end
  end

  // Filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      tick_counter <= '0;
      avg_short    <= '0;
      avg_medium   <= '0;
      avg_long     <= '0;
    end else if (adv) begin
      seeded       <= 1'b1;
      tick_counter <= tick_counter_next;
      avg_short    <= avg_short_next;
      avg_medium   <= avg_medium_next;
      avg_long     <= avg_long_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      load.valid <= 1'b0;
    end else if (adv) begin
      load.valid <= 1'b1;
    end else if (load.ready) begin
      load.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      load.load_one     <= avg_short_next;
      load.load_five    <= avg_medium_next;
      load.load_fifteen <= avg_long_next;
      load.updated      <= updated_next;
    end
  end

  a_seed_equal: assert property (@(posedge clk) disable iff (rst)
    (adv && !seeded) |=> (avg_short == avg_medium && avg_medium == avg_long))
    else $error("averages differ after seeding");

  a_hit_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && seeded && hit) |=> (tick_counter == '0 && load.updated))
    else $error("prescaler not cleared on update");

  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> load.valid)
    else $error("result lost after advance");

  a_seeded_holds: assert property (@(posedge clk) disable iff (rst)
    !$fell(seeded))
    else $error("seeded flag dropped without reset");

endmodule
`default_nettype wire

>>> hw/rtl/lavg_cfg.sv
// Configuration registers of the load average filter.
`default_nettype none
module lavg_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [lavg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lavg_pkg::CFG_DATA_W-1:0]     cfg_data,
  output lavg_pkg::cfg_t                           cfg
);

  lavg_pkg::cfg_idx_t idx;

  assign idx = lavg_pkg::cfg_idx_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval <= lavg_pkg::INTERVAL_RST;
      cfg.decay_short     <= lavg_pkg::DECAY_SHORT_RST;
      cfg.decay_medium    <= lavg_pkg::DECAY_MEDIUM_RST;
      cfg.decay_long      <= lavg_pkg::DECAY_LONG_RST;
    end else if (cfg_we) begin
      unique case (idx)
        lavg_pkg::CFG_SAMPLE_INTERVAL: begin
          cfg.sample_interval <= cfg_data[lavg_pkg::INTERVAL_W-1:0];
        end
        lavg_pkg::CFG_DECAY_SHORT: begin
          cfg.decay_short <= cfg_data[lavg_pkg::DECAY_W-1:0];
        end
        lavg_pkg::CFG_DECAY_MEDIUM: begin
          cfg.decay_medium <= cfg_data[lavg_pkg::DECAY_W-1:0];
        end
        lavg_pkg::CFG_DECAY_LONG: begin
          cfg.decay_long <= cfg_data[lavg_pkg::DECAY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/lavg_decay.sv
// One exponential decay step of a load average.
`default_nettype none
module lavg_decay (
  input  wire logic [lavg_pkg::LOAD_W-1:0]   load,
  input  wire logic [lavg_pkg::DECAY_W-1:0]  decay,
  input  wire logic [lavg_pkg::COUNT_W-1:0]  count,
  output      logic [lavg_pkg::LOAD_W-1:0]   load_next
);

  localparam int PROD_W = lavg_pkg::LOAD_W + lavg_pkg::DECAY_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int RES_W  = ACC_W - lavg_pkg::FRAC_BITS;

  logic [lavg_pkg::DECAY_W-1:0]                     d;
  logic [lavg_pkg::DECAY_W-1:0]                     wd;
  logic [PROD_W-1:0]                                old_part;
  logic [lavg_pkg::COUNT_W+lavg_pkg::DECAY_W-1:0]   new_part;
  logic [ACC_W-1:0]                                 acc;
  logic [RES_W-1:0]                                 res;

  always_comb begin
    d        = (decay > lavg_pkg::DECAY_ONE) ? lavg_pkg::DECAY_ONE : decay;
    wd       = lavg_pkg::DECAY_ONE - d;
    old_part = PROD_W'(load) * PROD_W'(d);
    new_part = (lavg_pkg::COUNT_W + lavg_pkg::DECAY_W)'(count) *
               (lavg_pkg::COUNT_W + lavg_pkg::DECAY_W)'(wd);
    acc      = ACC_W'(old_part)
             + (ACC_W'(new_part) << lavg_pkg::FRAC_BITS)
             + (ACC_W'(1) << (lavg_pkg::FRAC_BITS - 1));
    res      = acc[ACC_W-1:lavg_pkg::FRAC_BITS];
    load_next = (res > RES_W'(lavg_pkg::LOAD_MAX)) ? lavg_pkg::LOAD_MAX
                                                   : res[lavg_pkg::LOAD_W-1:0];
  end

endmodule
`default_nettype wire
